// ===== rtl/betp_pkg.sv =====
`timescale 1ns / 1ps
package betp_pkg;
   localparam int TIME_W = 48;
   localparam int DLY_W  = 40;
   localparam int DISP_W = 35;
   localparam int DIST_W = 36;
   localparam int QUO_W  = 53;
   localparam int DIV_W  = 32;

   localparam logic [1:0] OUT_STATIC_IN  = 2'd0;
   localparam logic [1:0] OUT_STATIC_OUT = 2'd1;
   localparam logic [1:0] OUT_NO_BOX     = 2'd2;
   localparam logic [1:0] OUT_EXIT       = 2'd3;

   localparam logic [1:0] CSR_BOXES = 2'd0;
   localparam logic [1:0] CSR_EPS   = 2'd1;
   localparam logic [1:0] CSR_RECHK = 2'd2;
   localparam logic [1:0] CSR_FAR   = 2'd3;

   typedef struct packed {
      logic signed [31:0] lo_x;
      logic signed [31:0] lo_y;
      logic signed [31:0] lo_z;
      logic signed [31:0] hi_x;
      logic signed [31:0] hi_y;
      logic signed [31:0] hi_z;
   } box_type;

   typedef struct packed {
      logic             start;
      logic [QUO_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic             busy;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;
endpackage

// ===== rtl/box_exit_time_predictor.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata (low bit first)                                      | tuser
// req     | in  | box_index,a_x,a_y,a_z,b_x,b_y,b_z,sample_time,current_time | req_type
// rsp     | out | next_event_time,exit_delay,found_box                       | outcome
// csr     | in  | csr_index selects register, csr_wdata up to 40 bits        | -
// A query extrapolates through one shared 32x24 multiplier, scans the boxes
// from the box RAM, and makes up to 3 divisions on the shared serial divider.
// reset is synchronous; the box table is not cleared. req_tready is low while an
// item is in work and while a result waits in the output register.
module box_exit_time_predictor #(
   parameter int MAX_BOXES = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [295:0] req_tdata,  // box_index,a_x,a_y,a_z,b_x,b_y,b_z,sample,current,pad
   input  logic         req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // next_event_time,exit_delay,found_box,pad
   output logic [1:0]   rsp_tuser,  // outcome
   input  logic         csr_wen,
   input  logic [1:0]   csr_index,
   input  logic [39:0]  csr_wdata
);
   localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int NW = $clog2(MAX_BOXES + 1);
   localparam int TW = betp_pkg::TIME_W;
   localparam int LW = betp_pkg::DLY_W;

   localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_DISP = 4'd2, S_RD = 4'd3,
      S_WAIT = 4'd4, S_TEST = 4'd5, S_AXIS = 4'd6, S_DIVW = 4'd7, S_FIN = 4'd8,
      S_OUT = 4'd9;

   logic [3:0]  st_ff, st_in;
   logic [3:0]  boxes_ff;
   logic [15:0] eps_ff;
   logic [31:0] rechk_ff;
   logic [LW-1:0] far_ff;

   logic [2:0]  bidx;
   logic signed [31:0] ain [3];
   logic signed [31:0] bin [3];
   logic [TW-1:0] smp, cur;
   assign bidx = req_tdata[2:0];
   assign ain[0] = req_tdata[34:3];
   assign ain[1] = req_tdata[66:35];
   assign ain[2] = req_tdata[98:67];
   assign bin[0] = req_tdata[130:99];
   assign bin[1] = req_tdata[162:131];
   assign bin[2] = req_tdata[194:163];
   assign smp = req_tdata[242:195];
   assign cur = req_tdata[290:243];

   logic signed [33:0] p_ff [3];
   logic signed [33:0] p_in [3];
   logic signed [31:0] v_ff [3];
   logic [TW-1:0] cur_ff, adt_ff;
   logic dtneg_ff, static_ff;
   logic [1:0] ax_ff, ax_in;
   logic       half_ff, half_in;
   logic [55:0] prod_ff;
   logic [36:0] acc_ff, acc_in;
   logic [NW-1:0] bi_ff, bi_in;
   logic [AW-1:0] fi_ff, fi_in;
   logic [LW-1:0] best_ff, best_in;
   logic [1:0] outc_ff, outc_in;
   logic [TW-1:0] nxt_ff, nxt_in;
   logic [LW-1:0] dly_ff, dly_in;
   logic [2:0] fb_ff, fb_in;

   // box RAM
   betp_pkg::box_type rd_box, wr_box;
   logic ram_we;
   logic [AW-1:0] rd_addr;
   assign wr_box = {ain[0], ain[1], ain[2], bin[0], bin[1], bin[2]};
   assign ram_we = req_tvalid && req_tready && !req_tuser && (32'(bidx) < MAX_BOXES);
   assign rd_addr = bi_ff[AW-1:0];
   betp_ram #(.WIDTH($bits(betp_pkg::box_type)), .DEPTH(MAX_BOXES)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(AW'(bidx)), .wr_data(wr_box),
      .rd_addr(rd_addr), .rd_data(rd_box));

   betp_pkg::div_req_type dreq;
   betp_pkg::div_rsp_type drsp;
   betp_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [NW-1:0] nscan;
   assign nscan = (32'(boxes_ff) > MAX_BOXES) ? NW'(MAX_BOXES) : NW'(boxes_ff);

   logic [31:0] av_cur;
   logic [23:0] mop;
   logic signed [31:0] vsel, lo_sel, hi_sel;
   logic signed [33:0] psel;
   logic signed [34:0] fwd_dist;
   logic [LW-1:0] quo_sat;
   logic holds;
   logic [TW:0] sum;

   always_comb begin
      vsel   = v_ff[ax_ff];
      psel   = p_ff[ax_ff];
      av_cur = vsel[31] ? 32'(-vsel) : 32'(vsel);
      mop    = half_ff ? adt_ff[47:24] : adt_ff[23:0];
      case (ax_ff)
         2'd0: begin lo_sel = rd_box.lo_x; hi_sel = rd_box.hi_x; end
         2'd1: begin lo_sel = rd_box.lo_y; hi_sel = rd_box.hi_y; end
         default: begin lo_sel = rd_box.lo_z; hi_sel = rd_box.hi_z; end
      endcase
      fwd_dist = (vsel > 0) ? (35'(hi_sel) - 35'(psel)) : (35'(psel) - 35'(lo_sel));
      quo_sat = (drsp.quotient > 53'(far_ff)) ? far_ff : drsp.quotient[LW-1:0];
      holds = (p_ff[0] >= 34'(rd_box.lo_x)) && (p_ff[0] <= 34'(rd_box.hi_x)) &&
              (p_ff[1] >= 34'(rd_box.lo_y)) && (p_ff[1] <= 34'(rd_box.hi_y)) &&
              (p_ff[2] >= 34'(rd_box.lo_z)) && (p_ff[2] <= 34'(rd_box.hi_z));
      sum = {1'b0, cur_ff} + (TW+1)'(best_ff);
   end

   always_comb begin
      logic [40:0] d;
      logic [34:0] dc;
      st_in = st_ff; ax_in = ax_ff; half_in = half_ff; acc_in = acc_ff;
      bi_in = bi_ff; fi_in = fi_ff; best_in = best_ff; outc_in = outc_ff;
      nxt_in = nxt_ff; dly_in = dly_ff; fb_in = fb_ff;
      p_in = p_ff;
      dreq = '0;
      d = '0; dc = '0;
      case (st_ff)
         S_IDLE: if (req_tvalid && req_tuser) begin
            st_in = (bin[0] == 0 && bin[1] == 0 && bin[2] == 0) ? S_RD : S_MUL;
            for (int k = 0; k < 3; k++) p_in[k] = 34'(ain[k]);
            ax_in = 2'd0; half_in = 1'b1; acc_in = '0; bi_in = '0;
         end
         S_MUL: st_in = S_DISP;
         S_DISP: begin
            if (half_ff) begin
               acc_in  = (prod_ff[55:29] != 0) ? 37'h1_0000_0000_0 : 37'(prod_ff) << 8;
               half_in = 1'b0;
               st_in   = S_MUL;
            end else begin
               d = 41'(acc_ff) + 41'(prod_ff >> 16);
               dc = (d > 41'(64'd1 << 33)) ? 35'(64'd1 << 33) : d[34:0];
               p_in[ax_ff] = ((vsel < 0) != dtneg_ff) ? psel - 34'(dc) : psel + 34'(dc);
               half_in = 1'b1;
               acc_in  = '0;
               if (ax_ff == 2'd2) begin
                  ax_in = 2'd0; st_in = S_RD;
               end else begin
                  ax_in = ax_ff + 1'b1; st_in = S_MUL;
               end
            end
         end
         S_RD: begin
            if (bi_ff >= nscan) begin
               outc_in = static_ff ? betp_pkg::OUT_STATIC_OUT : betp_pkg::OUT_NO_BOX;
               nxt_in = cur_ff; dly_in = '0; fb_in = '0;
               st_in = S_OUT;
            end else st_in = S_WAIT;
         end
         S_WAIT: st_in = S_TEST;
         S_TEST: begin
            if (holds) begin
               fi_in = bi_ff[AW-1:0];
               if (static_ff) begin
                  outc_in = betp_pkg::OUT_STATIC_IN;
                  best_in = LW'(rechk_ff);
                  st_in = S_FIN;
               end else begin
                  best_in = far_ff; ax_in = 2'd0; st_in = S_AXIS;
               end
            end else begin
               bi_in = bi_ff + 1'b1; st_in = S_RD;
            end
         end
         S_AXIS: begin
            if (av_cur == 0 || av_cur < 32'(eps_ff)) begin
               if (ax_ff == 2'd2) st_in = S_FIN; else ax_in = ax_ff + 1'b1;
            end else begin
               dreq.start = 1'b1;
               dreq.dividend = fwd_dist[34] ? '0 : 53'({fwd_dist[33:0], 16'd0});
               dreq.divisor = av_cur;
               st_in = S_DIVW;
            end
            outc_in = betp_pkg::OUT_EXIT;
         end
         S_DIVW: if (drsp.done) begin
            if (quo_sat < best_ff) best_in = quo_sat;
            if (ax_ff == 2'd2) st_in = S_FIN;
            else begin ax_in = ax_ff + 1'b1; st_in = S_AXIS; end
         end
         S_FIN: begin
            nxt_in = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
            dly_in = best_ff;
            fb_in  = static_ff ? 3'd0 : 3'(fi_ff);
            st_in  = S_OUT;
         end
         S_OUT: if (rsp_tready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         boxes_ff <= '0;
         eps_ff   <= 16'd1;
         rechk_ff <= 32'd6553600;
         far_ff   <= 40'd6553600000;
      end else begin
         st_ff <= st_in;
         if (csr_wen) begin
            case (csr_index)
               betp_pkg::CSR_BOXES: boxes_ff <= csr_wdata[3:0];
               betp_pkg::CSR_EPS:   eps_ff   <= csr_wdata[15:0];
               betp_pkg::CSR_RECHK: rechk_ff <= csr_wdata[31:0];
               betp_pkg::CSR_FAR:   far_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (req_tvalid && req_tready && req_tuser) begin
         for (int k = 0; k < 3; k++) v_ff[k] <= bin[k];
         cur_ff   <= cur;
         dtneg_ff <= smp > cur;
         adt_ff   <= (smp > cur) ? smp - cur : cur - smp;
         static_ff <= (bin[0] == 0 && bin[1] == 0 && bin[2] == 0);
      end
      prod_ff <= 56'(av_cur) * 56'(mop);
      p_ff <= p_in; ax_ff <= ax_in; half_ff <= half_in; acc_ff <= acc_in;
      bi_ff <= bi_in; fi_ff <= fi_in; best_ff <= best_in; outc_ff <= outc_in;
      nxt_ff <= nxt_in; dly_ff <= dly_in; fb_ff <= fb_in;
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tdata  = {5'd0, fb_ff, dly_ff, nxt_ff};
   assign rsp_tuser  = outc_ff;

   a_div_only_in_axis: assert property (@(posedge clock) disable iff (reset)
      dreq.start |-> (st_ff == S_AXIS && !drsp.busy))
      else $error("divider started while busy");
   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(st_ff) == S_FIN || $past(st_ff) == S_RD))
      else $error("result without finish");
   a_exit_bounded: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == betp_pkg::OUT_EXIT) |-> (dly_ff <= far_ff))
      else $error("exit delay above ceiling");
endmodule

// ===== rtl/betp_ram.sv =====
`timescale 1ns / 1ps
module betp_ram #(
   parameter int WIDTH = 192,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/betp_div.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module betp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  betp_pkg::div_req_type req,
   output betp_pkg::div_rsp_type rsp
);
   localparam int QW = betp_pkg::QUO_W;
   localparam int DW = betp_pkg::DIV_W;

   logic [QW-1:0]         quo_ff, quo_in;
   logic [DW:0]           rem_ff, rem_in;
   logic [DW-1:0]         den_ff, den_in;
   logic [$clog2(QW+1)-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [DW+1:0]         trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = ($clog2(QW+1))'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[QW-1]} - {2'b00, den_ff};
         if (!trial[DW+1]) begin
            rem_in = trial[DW:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DW-1:0], quo_ff[QW-1]};
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.busy     = busy_ff;
   assign rsp.quotient = quo_ff;
endmodule

// ===== verif/tb_box_exit_time_predictor.sv =====
`timescale 1ns / 1ps
module tb_box_exit_time_predictor;

   localparam bit      REQ_LOAD  = 1'b0;
   localparam bit      REQ_QUERY = 1'b1;
   localparam int      NBOX      = 8;
   localparam longint  CYCLE_LIMIT = 3_000_000;
   localparam int      DRAIN_CYCLES = 250;
   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [63:0] DISP_MAX = 64'd1 << 33;

   typedef struct {
      bit              kind;
      logic [2:0]      slot;
      logic [2:0][31:0] a;
      logic [2:0][31:0] b;
      logic [47:0]     t_smp;
      logic [47:0]     t_cur;
   } box_req_type;

   typedef struct {
      logic [47:0] next_time;
      logic [39:0] delay;
      logic [1:0]  outcome;
      logic [2:0]  box;
   } exit_res_type;

   typedef struct {
      box_req_type  req;
      bit           typed;
      exit_res_type res;
   } dir_row_type;

   logic         clock, reset;
   logic         req_tvalid, req_tready, req_tuser;
   logic [295:0] req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_wen;
   logic [1:0]   csr_index;
   logic [39:0]  csr_wdata;

   box_exit_time_predictor #(.MAX_BOXES(NBOX)) dut (.*);

   // model state
   longint      tbl_lo[NBOX][3], tbl_hi[NBOX][3];
   logic [3:0]  m_boxes;
   logic [15:0] m_eps;
   logic [31:0] m_rechk;
   logic [39:0] m_far;

   exit_res_type pending_exits[$];
   dir_row_type  dir_rows[$];
   int           mismatches, n_loads, n_queries;
   int           outcome_seen[4];
   longint       cycles;
   bit           tx_burst, rx_burst;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   function automatic bit box_holds(int k, longint p[3]);
      for (int j = 0; j < 3; j++)
         if (p[j] < tbl_lo[k][j] || p[j] > tbl_hi[k][j]) return 0;
      return 1;
   endfunction

   function automatic logic [63:0] sat_time(logic [63:0] t, logic [63:0] d);
      logic [63:0] s;
      s = t + d;
      return (s > 64'(TIME_MAX)) ? 64'(TIME_MAX) : s;
   endfunction

   // Apply one transfer to the model; returns 1 when it yields a result.
   function automatic bit predict_exit(box_req_type r, output exit_res_type e);
      longint      av_s[3], p[3], fwd_dist;
      logic [63:0] adt, av, d, t, best, ud;
      bit          dt_neg, neg, found;
      int          n, fi;
      n = (m_boxes > NBOX) ? NBOX : m_boxes;
      for (int j = 0; j < 3; j++) av_s[j] = longint'($signed(r.b[j]));
      if (r.kind == REQ_LOAD) begin
         for (int j = 0; j < 3; j++) begin
            tbl_lo[r.slot][j] = longint'($signed(r.a[j]));
            tbl_hi[r.slot][j] = av_s[j];
         end
         return 0;
      end
      e.box = 3'd0;
      if (av_s[0] == 0 && av_s[1] == 0 && av_s[2] == 0) begin
         for (int j = 0; j < 3; j++) p[j] = longint'($signed(r.a[j]));
         found = 0;
         for (int k = 0; k < n; k++) if (!found && box_holds(k, p)) found = 1;
         e.outcome   = found ? betp_pkg::OUT_STATIC_IN : betp_pkg::OUT_STATIC_OUT;
         e.delay     = found ? 40'(m_rechk) : 40'd0;
         e.next_time = 48'(sat_time(64'(r.t_cur), found ? 64'(m_rechk) : 64'd0));
         return 1;
      end
      dt_neg = r.t_smp > r.t_cur;
      adt = dt_neg ? 64'(r.t_smp - r.t_cur) : 64'(r.t_cur - r.t_smp);
      for (int j = 0; j < 3; j++) begin
         av = (av_s[j] < 0) ? 64'(-av_s[j]) : 64'(av_s[j]);
         d = ((av * (adt >> 24)) << 8) + ((av * (adt & 64'hFF_FFFF)) >> 16);
         if (d > DISP_MAX) d = DISP_MAX;
         neg = (av_s[j] < 0) != dt_neg;
         p[j] = neg ? longint'($signed(r.a[j])) - longint'(d)
                    : longint'($signed(r.a[j])) + longint'(d);
      end
      found = 0;
      fi = 0;
      for (int k = 0; k < n; k++)
         if (!found && box_holds(k, p)) begin
            found = 1;
            fi = k;
         end
      if (!found) begin
         e.outcome   = betp_pkg::OUT_NO_BOX;
         e.delay     = 40'd0;
         e.next_time = r.t_cur;
         return 1;
      end
      best = 64'(m_far);
      for (int j = 0; j < 3; j++) begin
         av = (av_s[j] < 0) ? 64'(-av_s[j]) : 64'(av_s[j]);
         if (av == 0 || av < 64'(m_eps)) t = 64'(m_far);
         else begin
            fwd_dist = (av_s[j] > 0) ? tbl_hi[fi][j] - p[j] : p[j] - tbl_lo[fi][j];
            ud = (fwd_dist < 0) ? 64'd0 : 64'(fwd_dist);
            t = (ud << 16) / av;
            if (t > 64'(m_far)) t = 64'(m_far);
         end
         if (t < best) best = t;
      end
      e.outcome   = betp_pkg::OUT_EXIT;
      e.delay     = 40'(best);
      e.next_time = 48'(sat_time(64'(r.t_cur), best));
      e.box       = 3'(fi);
      return 1;
   endfunction

   task automatic send_req(box_req_type r, bit typed, exit_res_type typed_res);
      int           gap;
      exit_res_type e;
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {5'd0, r.t_cur, r.t_smp, r.b[2], r.b[1], r.b[0],
                     r.a[2], r.a[1], r.a[0], r.slot};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      if (predict_exit(r, e)) begin
         pending_exits.push_back(typed ? typed_res : e);
         n_queries++;
      end else n_loads++;
   endtask

   task automatic set_config(logic [3:0] nb, logic [15:0] eps, logic [31:0] rc,
                             logic [39:0] far);
      logic [39:0] vals[4];
      vals = '{40'(nb), 40'(eps), 40'(rc), far};
      req_tvalid <= 1'b0;
      wait (pending_exits.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_wen   <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wen <= 1'b0;
      m_boxes = nb;
      m_eps   = eps;
      m_rechk = rc;
      m_far   = far;
   endtask

   function automatic box_req_type mk(bit kind, logic [2:0] slot,
                                   logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                   logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                   logic [47:0] ts, logic [47:0] tc);
      box_req_type r;
      r.kind = kind;
      r.slot = slot;
      r.a = {az, ay, ax};
      r.b = {bz, by, bx};
      r.t_smp = ts;
      r.t_cur = tc;
      return r;
   endfunction

   function automatic void add_row(box_req_type r, bit typed = 0,
                                   exit_res_type e = '{0, 0, 0, 0});
      dir_rows.push_back('{r, typed, e});
   endfunction

   function automatic logic [31:0] rnd_vel();
      int unsigned m;
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom;
         2: m = 1 << 8;
         3: m = 1 << 16;
         default: m = 1 << 20;
      endcase
      v = $urandom_range(0, m);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic box_req_type rnd_load();
      box_req_type r;
      longint      c, h;
      r = mk(REQ_LOAD, 3'($urandom), $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
      if ($urandom_range(0, 4) != 0)
         for (int j = 0; j < 3; j++) begin
            c = longint'($signed(32'($urandom))) >>> 3;
            h = c + $urandom_range(0, 1 << 24);
            r.a[j] = 32'(c);
            r.b[j] = 32'(h > 64'sh7FFF_FFFF ? 64'sh7FFF_FFFF : h);
         end
      return r;
   endfunction

   function automatic box_req_type rnd_query();
      box_req_type r;
      int          k;
      longint      span;
      r = mk(REQ_QUERY, 3'($urandom), $urandom, $urandom, $urandom,
             rnd_vel(), rnd_vel(), rnd_vel(), {$urandom, $urandom}, {$urandom, $urandom});
      if ($urandom_range(0, 9) < 2) r.b = '0;
      if ($urandom_range(0, 4) != 0) begin
         k = $urandom_range(0, NBOX - 1);
         for (int j = 0; j < 3; j++)
            if (tbl_lo[k][j] <= tbl_hi[k][j]) begin
               span = tbl_hi[k][j] - tbl_lo[k][j] + 1;
               r.a[j] = 32'(tbl_lo[k][j] + longint'({$urandom, $urandom} % span));
            end
         r.t_cur = $urandom_range(0, 1) ? r.t_smp + $urandom_range(0, 1 << 20)
                                        : r.t_smp - $urandom_range(0, 1 << 18);
      end
      return r;
   endfunction

   // result side
   initial begin
      int           gap;
      exit_res_type got, want;
      logic [95:0]  dat;
      logic [1:0]   usr;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         gap = rx_burst ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         dat = rsp_tdata;
         usr = rsp_tuser;
         @(posedge clock);
         got = '{dat[47:0], dat[87:48], usr, dat[90:88]};
         if (pending_exits.size() == 0) begin
            report_mismatch("result without a query", 64'(got.next_time), 64'd0);
            continue;
         end
         want = pending_exits.pop_front();
         outcome_seen[want.outcome]++;
         if (got.next_time !== want.next_time)
            report_mismatch("next_event_time", 64'(got.next_time), 64'(want.next_time));
         if (got.delay !== want.delay)
            report_mismatch("exit_delay", 64'(got.delay), 64'(want.delay));
         if (got.outcome !== want.outcome)
            report_mismatch("outcome", 64'(got.outcome), 64'(want.outcome));
         if (got.box !== want.box)
            report_mismatch("found_box", 64'(got.box), 64'(want.box));
      end
   end

   initial begin
      logic [39:0] cfg_far;
      cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_index = betp_pkg::CSR_BOXES;
      csr_wdata = '0;
      tx_burst = 0;
      rx_burst = 0;
      m_boxes = 4'd0;
      m_eps = 16'd1;
      m_rechk = 32'd6553600;
      m_far = 40'd6553600000;
      for (int k = 0; k < NBOX; k++)
         for (int j = 0; j < 3; j++) begin
            tbl_lo[k][j] = 0;
            tbl_hi[k][j] = 0;
         end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // after reset no box is scanned
      add_row(mk(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              '{0, 0, betp_pkg::OUT_STATIC_OUT, 0});
      add_row(mk(REQ_QUERY, 7, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0,
                 TIME_MAX, TIME_MAX), 1, '{TIME_MAX, 0, betp_pkg::OUT_STATIC_OUT, 0});
      add_row(mk(REQ_QUERY, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, TIME_MAX),
              1, '{TIME_MAX, 0, betp_pkg::OUT_NO_BOX, 0});
      add_row(mk(REQ_QUERY, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 TIME_MAX, 0), 1, '{0, 0, betp_pkg::OUT_NO_BOX, 0});
      // table contents
      add_row(mk(REQ_LOAD, 0, 0, 0, 0, 655360, 655360, 655360, 0, 0));
      add_row(mk(REQ_LOAD, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, TIME_MAX, TIME_MAX));
      add_row(mk(REQ_LOAD, 2, 100, 100, 100, -100, -100, -100, 0, 0));
      add_row(mk(REQ_LOAD, 3, 5 << 16, -(3 << 16), 7 << 16, 5 << 16, -(3 << 16), 7 << 16, 0, 0));
      for (int k = 4; k < NBOX; k++) begin
         dir_rows.push_back('{rnd_load(), 0, '{0, 0, 0, 0}});
         dir_rows[$].req.slot = 3'(k);
      end
      foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
      dir_rows.delete();

      set_config(4'd8, 16'd1, 32'd6553600, 40'd6553600000);
      add_row(mk(REQ_QUERY, 0, 655360, 0, 655360, 0, 0, 0, 100, 200));
      add_row(mk(REQ_QUERY, 0, 5 << 16, -(3 << 16), 7 << 16, 0, 0, 0, 0, TIME_MAX));
      add_row(mk(REQ_QUERY, 0, 1 << 16, 1 << 16, 1 << 16, 1 << 16, 0, 0, 500, 500));
      add_row(mk(REQ_QUERY, 0, 1 << 16, 1 << 16, 1 << 16, -1, -1, 1, 1 << 20, 5));
      add_row(mk(REQ_QUERY, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, TIME_MAX));
      add_row(mk(REQ_QUERY, 0, -(1 << 20), 0, 0, 1, 0, 0, 0, 1 << 16));
      add_row(mk(REQ_QUERY, 0, 9 << 16, 9 << 16, 9 << 16, 3 << 16, -(2 << 16), 1 << 14,
                 1 << 16, 1 << 15));
      add_row(mk(REQ_QUERY, 0, 5 << 16, -(3 << 16), 7 << 16, 0, 0, 1 << 16, 0, TIME_MAX - 5));
      foreach (dir_rows[i]) send_req(dir_rows[i].req, 0, '{0, 0, 0, 0});

      for (int ph = 0; ph < 6; ph++) begin
         cfg_far = {$urandom, $urandom};
         case (ph)
            0: set_config(4'd8, 16'd1, 32'd6553600, 40'd6553600000);
            1: set_config(4'd15, 16'd0, 32'd0, 40'd0);
            2: set_config(4'd3, 16'hFFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
            3: set_config(4'd8, 16'd256, $urandom, cfg_far);
            4: set_config(4'd0, 16'($urandom), $urandom, cfg_far);
            default: set_config(4'd9, 16'd16, 32'd655360, 40'd6553600);
         endcase
         for (int i = 0; i < 300; i++) begin
            if (i % 60 == 0) begin
               tx_burst = ($urandom_range(0, 3) == 0);
               rx_burst = ($urandom_range(0, 3) == 0);
            end
            send_req(($urandom_range(0, 9) == 0) ? rnd_load() : rnd_query(), 0,
                     '{0, 0, 0, 0});
         end
      end

      req_tvalid <= 1'b0;
      wait (pending_exits.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d box loads and %0d queries over 7 register settings",
               n_loads, n_queries);
      $display("Outcomes: static in %0d, static out %0d, no box %0d, exit %0d",
               outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3]);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/betp_pkg.sv
rtl/betp_ram.sv
rtl/betp_div.sv
rtl/box_exit_time_predictor.sv
verif/tb_box_exit_time_predictor.sv
